### design/bbdh_pkg.sv
// Shared types and constants for the baseband frame deheader.
package bbdh_pkg;

    localparam int unsigned HEADER_BITS = 80;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [7:0]  CRC_POLY    = 8'hD5;

    typedef enum logic [2:0] {
        ST_DATA         = 3'd0,
        ST_CRC_FAIL     = 3'd1,
        ST_DFL_LONG     = 3'd2,
        ST_DFL_ALIGN    = 3'd3,
        ST_SYNCD_BEYOND = 3'd4,
        ST_SYNCD_ALIGN  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        t_status    status;
        logic       frame_last;
    } t_result;

endpackage

### design/baseband_frame_deheader.sv
// Baseband frame deheader top level: bit parser front end, result queue back end.
// Each result is written into the result queue and is shown on the output from there.
// Throughput: one bit per cycle; the parser stalls only when the 4-entry result
// queue is full, which drops o_ready.
// Reset: i_rst_n synchronous, active low; clears sync, frame state and the queue.
module baseband_frame_deheader #(
    parameter int unsigned MAX_FRAME_BITS = 58192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_data_bit,
    input  logic        i_frame_start,
    input  logic [15:0] i_frame_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic        o_frame_last
);
    import bbdh_pkg::*;

    logic    full, push, fire;
    t_result push_res, out_res;

    assign o_ready = !full;
    assign fire    = i_valid && !full;

    bbdh_front #(.MAX_FRAME_BITS(MAX_FRAME_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_data_bit    (i_data_bit),
        .i_frame_start (i_frame_start),
        .i_frame_bits  (i_frame_bits),
        .o_push        (push),
        .o_result      (push_res)
    );

    bbdh_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (push_res),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_res)
    );

    assign o_data_byte  = out_res.data_byte;
    assign o_status     = out_res.status;
    assign o_frame_last = out_res.frame_last;

endmodule

### design/bbdh_front.sv
// Front end: header CRC and checks, skip, byte packing; one result per bit at most.
module bbdh_front #(
    parameter int unsigned MAX_FRAME_BITS = 58192
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_data_bit,
    input  logic             i_frame_start,
    input  logic [15:0]      i_frame_bits,
    output logic             o_push,
    output bbdh_pkg::t_result o_result
);
    import bbdh_pkg::*;

    localparam logic [15:0] HDR_LEN   = 16'(HEADER_BITS);
    localparam logic [15:0] MAX_LEN   = 16'(MAX_FRAME_BITS);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [15:0] r_max_dfl, n_max_dfl;
    logic [7:0]  r_crc, n_crc;
    logic [63:0] r_shift, n_shift;
    logic [15:0] r_skip, n_skip;
    logic [15:0] r_data, n_data;
    logic [7:0]  r_asm, n_asm;
    logic [2:0]  r_nbits, n_nbits;
    logic        r_in_sync, n_in_sync;
    logic        r_dropped, n_dropped;

    logic [15:0] v_len, c_pos, c_len, c_max_dfl, c_skip, c_data, dfl, syncd;
    logic [7:0]  c_crc, c_asm, crc_next, asm_next;
    logic [63:0] c_shift, shift_next;
    logic [2:0]  c_nbits, nbits_next;
    logic        c_dropped;
    logic [16:0] skip_sum;
    t_status     st;

    always_comb begin
        v_len = i_frame_bits;
        if (i_frame_bits < HDR_LEN) v_len = HDR_LEN;
        if (i_frame_bits > MAX_LEN) v_len = MAX_LEN;

        if (i_frame_start) begin
            c_pos = '0; c_len = v_len; c_max_dfl = v_len - HDR_LEN;
            c_crc = '0; c_shift = '0; c_skip = '0; c_data = '0;
            c_asm = '0; c_nbits = '0; c_dropped = 1'b0;
        end else begin
            c_pos = r_pos; c_len = r_len; c_max_dfl = r_max_dfl;
            c_crc = r_crc; c_shift = r_shift; c_skip = r_skip; c_data = r_data;
            c_asm = r_asm; c_nbits = r_nbits; c_dropped = r_dropped;
        end

        crc_next   = {c_crc[6:0], 1'b0} ^ ((c_crc[7] ^ i_data_bit) ? CRC_POLY : 8'h00);
        shift_next = {c_shift[62:0], i_data_bit};
        dfl        = shift_next[47:32];
        syncd      = shift_next[23:8];
        skip_sum   = {1'b0, syncd} + 17'd8;
        asm_next   = {c_asm[6:0], i_data_bit};
        nbits_next = c_nbits + 3'd1;

        if (crc_next != 8'h00)            st = ST_CRC_FAIL;
        else if (dfl > c_max_dfl)         st = ST_DFL_LONG;
        else if (dfl[2:0] != 3'd0)        st = ST_DFL_ALIGN;
        else if (syncd > dfl)             st = ST_SYNCD_BEYOND;
        else if (syncd[2:0] != 3'd0)      st = ST_SYNCD_ALIGN;
        else                              st = ST_DATA;
    end

    always_comb begin
        n_pos = r_pos; n_len = r_len; n_max_dfl = r_max_dfl; n_crc = r_crc;
        n_shift = r_shift; n_skip = r_skip; n_data = r_data; n_asm = r_asm;
        n_nbits = r_nbits; n_in_sync = r_in_sync; n_dropped = r_dropped;
        o_push = 1'b0;
        o_result.data_byte  = '0;
        o_result.status     = ST_DATA;
        o_result.frame_last = 1'b0;
        if (i_fire) begin
            n_pos = c_pos; n_len = c_len; n_max_dfl = c_max_dfl; n_crc = c_crc;
            n_shift = c_shift; n_skip = c_skip; n_data = c_data; n_asm = c_asm;
            n_nbits = c_nbits; n_dropped = c_dropped;
            if (c_pos < c_len) begin
                n_pos = c_pos + 16'd1;
                if (!c_dropped) begin
                    if (c_pos < HDR_LEN) begin
                        n_crc   = crc_next;
                        n_shift = shift_next;
                        if (c_pos == HDR_LEN - 16'd1) begin
                            if (st != ST_DATA) begin
                                n_in_sync = 1'b0;
                                n_dropped = 1'b1;
                                o_push = 1'b1;
                                o_result.status     = st;
                                o_result.frame_last = 1'b1;
                            end else begin
                                n_asm   = '0;
                                n_nbits = '0;
                                if (!r_in_sync) begin
                                    n_skip = skip_sum[15:0];
                                    n_data = ({1'b0, dfl} > skip_sum) ?
                                             16'({1'b0, dfl} - skip_sum) : 16'd0;
                                    n_in_sync = 1'b1;
                                end else begin
                                    n_skip = '0;
                                    n_data = dfl;
                                end
                            end
                        end
                    end else if (c_skip != 16'd0) begin
                        n_skip = c_skip - 16'd1;
                    end else if (c_data != 16'd0) begin
                        n_data  = c_data - 16'd1;
                        n_nbits = nbits_next;
                        n_asm   = asm_next;
                        if (nbits_next == 3'd0) begin
                            n_asm = '0;
                            o_push = 1'b1;
                            o_result.data_byte  = asm_next;
                            o_result.frame_last = (c_data == 16'd1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_len <= '0; r_max_dfl <= '0; r_crc <= '0; r_shift <= '0;
            r_skip <= '0; r_data <= '0; r_asm <= '0; r_nbits <= '0;
            r_in_sync <= 1'b0; r_dropped <= 1'b0;
        end else begin
            r_pos <= n_pos; r_len <= n_len; r_max_dfl <= n_max_dfl; r_crc <= n_crc;
            r_shift <= n_shift; r_skip <= n_skip; r_data <= n_data; r_asm <= n_asm;
            r_nbits <= n_nbits; r_in_sync <= n_in_sync; r_dropped <= n_dropped;
        end
    end

endmodule

### design/bbdh_queue.sv
// Result queue between the parser and the output channel.
module bbdh_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bbdh_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output bbdh_pkg::t_result o_result
);
    import bbdh_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [QUEUE_CW-1:0]   r_cnt, n_cnt;
    logic                  pop;

    assign o_full   = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QUEUE_CW'(i_push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### bench/testbench.sv
// Self-checking bench for the baseband frame deheader: directed frame table, then random frames.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbdh_pkg::*;

    localparam int unsigned FRAME_BITS_MAX   = 58192;
    localparam int          RANDOM_BITS      = 300;
    localparam int          HOLD_CYCLES      = 300;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          PLAN_ROWS        = 19;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES
    } t_fill;

    typedef enum logic [2:0] {
        FAULT_CRC,
        FAULT_DFL_LONG,
        FAULT_DFL_ALIGN,
        FAULT_SYNCD_BEYOND,
        FAULT_SYNCD_ALIGN
    } t_fault;

    typedef struct packed {
        logic        start;
        logic [15:0] dfl;
        logic [15:0] syncd;
        logic        crc_ok;
        logic [15:0] len_field;
        logic [15:0] nbits;
        t_fill       fill;
        logic        typed;
        t_status     st;
    } t_frame_row;

    // start, dfl, syncd, crc_ok, frame_bits, bits sent, fill, typed, status
    localparam t_frame_row PLAN [PLAN_ROWS] = '{
        '{1'b0, 16'd0,  16'd0,  1'b1, 16'd0,   16'd5,   FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b1, 16'd64, 16'd16, 1'b1, 16'd152, 16'd152, FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b1, 16'd64, 16'd0,  1'b1, 16'd144, 16'd144, FILL_ONES,   1'b0, ST_DATA},
        '{1'b1, 16'd32, 16'd0,  1'b0, 16'd96,  16'd96,  FILL_RANDOM, 1'b1, ST_CRC_FAIL},
        '{1'b1, 16'd40, 16'd0,  1'b1, 16'd112, 16'd80,  FILL_RANDOM, 1'b1, ST_DFL_LONG},
        '{1'b1, 16'd36, 16'd0,  1'b1, 16'd120, 16'd80,  FILL_RANDOM, 1'b1, ST_DFL_ALIGN},
        '{1'b1, 16'd32, 16'd40, 1'b1, 16'd120, 16'd80,  FILL_RANDOM, 1'b1, ST_SYNCD_BEYOND},
        '{1'b1, 16'd32, 16'd4,  1'b1, 16'd120, 16'd80,  FILL_RANDOM, 1'b1, ST_SYNCD_ALIGN},
        '{1'b1, 16'd0,  16'd0,  1'b1, 16'd90,  16'd90,  FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b1, 16'd16, 16'd16, 1'b1, 16'd96,  16'd96,  FILL_ZEROS,  1'b0, ST_DATA},
        '{1'b1, 16'd64, 16'd0,  1'b1, 16'd144, 16'd100, FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b1, 16'd0,  16'd0,  1'b1, 16'd0,   16'd80,  FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b1, 16'd8,  16'd0,  1'b1, 16'd0,   16'd85,  FILL_RANDOM, 1'b1, ST_DFL_LONG},
        '{1'b1, 16'hFFF8, 16'd0, 1'b1, 16'hFFFF, 16'd82, FILL_RANDOM, 1'b1, ST_DFL_LONG},
        '{1'b1, 16'd8,  16'd8,  1'b1, 16'd104, 16'd104, FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b1, 16'd64, 16'hFFF8, 1'b1, 16'd200, 16'd80, FILL_RANDOM, 1'b1, ST_SYNCD_BEYOND},
        '{1'b1, 16'd16, 16'd0,  1'b1, 16'd96,  16'd96,  FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b1, 16'd24, 16'd8,  1'b1, 16'd120, 16'd120, FILL_RANDOM, 1'b0, ST_DATA},
        '{1'b0, 16'd0,  16'd0,  1'b1, 16'd0,   16'd4,   FILL_RANDOM, 1'b0, ST_DATA}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic        i_data_bit    = 1'b0;
    logic        i_frame_start = 1'b0;
    logic [15:0] i_frame_bits  = 16'd0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_status;
    logic        o_frame_last;

    // deframer state as predicted
    logic [15:0] fr_pos    = '0;
    logic [15:0] fr_len    = '0;
    logic [7:0]  hdr_crc   = '0;
    logic [63:0] hdr_shift = '0;
    logic [15:0] skip_left = '0;
    logic [15:0] data_left = '0;
    logic [7:0]  byte_acc  = '0;
    logic [2:0]  byte_bits = '0;
    bit          synced    = 1'b0;
    bit          dropped   = 1'b0;

    t_result deframed_q[$];
    int      bits_taken   = 0;
    int      fail_count   = 0;
    int      quiet_cycles = 0;
    int      tx_idle_pct  = 27;
    int      rx_idle_pct  = 82;
    bit      hold_want    = 1'b0;
    bit      hold_done    = 1'b0;
    int      hold_left    = 0;

    baseband_frame_deheader dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] crc8_shift(input logic [7:0] c, input logic b);
        return {c[6:0], 1'b0} ^ ((c[7] ^ b) ? CRC_POLY : 8'h00);
    endfunction

    task automatic deframe_bit(input logic b, input logic fs, input logic [15:0] fb,
                               output bit got, output t_result r, output bit counted);
        logic [15:0] dfl;
        logic [15:0] syncd;
        logic [15:0] room;
        logic [16:0] skip;
        t_status     st;
        got = 1'b0;
        r = '0;
        counted = 1'b0;
        if (fs) begin
            if (fb < HEADER_BITS) fr_len = 16'(HEADER_BITS);
            else if (fb > FRAME_BITS_MAX) fr_len = 16'(FRAME_BITS_MAX);
            else fr_len = fb;
            fr_pos = '0;
            hdr_crc = '0;
            hdr_shift = '0;
            skip_left = '0;
            data_left = '0;
            byte_acc = '0;
            byte_bits = '0;
            dropped = 1'b0;
        end
        if (fr_pos >= fr_len) return;
        counted = 1'b1;
        if (!dropped) begin
            if (fr_pos < HEADER_BITS) begin
                hdr_crc = crc8_shift(hdr_crc, b);
                hdr_shift = {hdr_shift[62:0], b};
                if (fr_pos == HEADER_BITS - 1) begin
                    dfl = hdr_shift[47:32];
                    syncd = hdr_shift[23:8];
                    room = fr_len - 16'(HEADER_BITS);
                    if (hdr_crc != 8'h00) st = ST_CRC_FAIL;
                    else if (dfl > room) st = ST_DFL_LONG;
                    else if (dfl[2:0] != 3'd0) st = ST_DFL_ALIGN;
                    else if (syncd > dfl) st = ST_SYNCD_BEYOND;
                    else if (syncd[2:0] != 3'd0) st = ST_SYNCD_ALIGN;
                    else st = ST_DATA;
                    if (st != ST_DATA) begin
                        synced = 1'b0;
                        dropped = 1'b1;
                        got = 1'b1;
                        r = t_result'{8'h00, st, 1'b1};
                    end else begin
                        skip = {1'b0, syncd} + 17'd8;
                        if (!synced) begin
                            skip_left = skip[15:0];
                            data_left = ({1'b0, dfl} > skip) ? dfl - skip[15:0] : 16'd0;
                            synced = 1'b1;
                        end else begin
                            skip_left = '0;
                            data_left = dfl;
                        end
                        byte_acc = '0;
                        byte_bits = '0;
                    end
                end
            end else if (skip_left != 0) begin
                skip_left--;
            end else if (data_left != 0) begin
                byte_acc = {byte_acc[6:0], b};
                data_left--;
                byte_bits++;
                if (byte_bits == 3'd0) begin
                    got = 1'b1;
                    r = t_result'{byte_acc, ST_DATA, data_left == 16'd0};
                    byte_acc = '0;
                end
            end
        end
        fr_pos++;
    endtask

    task automatic send_bit(input logic b, input logic fs, input logic [15:0] fb,
                            input bit typed, input t_status st);
        bit      got;
        bit      counted;
        t_result r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_bit <= b;
        i_frame_start <= fs;
        i_frame_bits <= fb;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        deframe_bit(b, fs, fb, got, r, counted);
        if (typed) deframed_q.push_back(t_result'{8'h00, st, 1'b1});
        else if (got) deframed_q.push_back(r);
        if (counted) bits_taken++;
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_bit(1'($urandom_range(1)), 1'b0, 16'($urandom_range(65535)), 1'b0, ST_DATA);
    endtask

    task automatic send_frame(input logic [15:0] dfl, input logic [15:0] syncd,
                              input bit crc_ok, input logic [15:0] len_field, input int nbits,
                              input t_fill fill, input bit typed, input t_status st);
        logic [79:0] hdr;
        logic [7:0]  crc;
        logic        b;
        int          i;
        hdr[79:48] = $urandom();
        hdr[47:32] = dfl;
        hdr[31:24] = 8'($urandom_range(255));
        hdr[23:8] = syncd;
        crc = '0;
        for (i = 79; i >= 8; i--) crc = crc8_shift(crc, hdr[i]);
        hdr[7:0] = crc_ok ? crc : crc ^ (8'h01 << $urandom_range(7));
        for (i = 0; i < nbits; i++) begin
            if (i < HEADER_BITS) b = hdr[79 - i];
            else if (fill == FILL_ZEROS) b = 1'b0;
            else if (fill == FILL_ONES) b = 1'b1;
            else b = 1'($urandom_range(1));
            send_bit(b, i == 0, (i == 0) ? len_field : 16'($urandom_range(65535)),
                     typed && i == HEADER_BITS - 1, st);
        end
    endtask

    task automatic random_frame(input bit force_long);
        int    len;
        int    dfl;
        int    syncd;
        int    k;
        int    nbits;
        bit    crc_ok;
        bit    wild;
        t_fill fill;
        k = force_long ? 12 : $urandom_range(12);
        dfl = 8 * k;
        syncd = force_long ? 0 : 8 * $urandom_range(k);
        len = 80 + dfl + (force_long ? 0 : $urandom_range(12));
        crc_ok = 1'b1;
        wild = 1'b0;
        case ($urandom_range(9))
            0: fill = FILL_ZEROS;
            1: fill = FILL_ONES;
            default: fill = FILL_RANDOM;
        endcase
        if (!force_long && $urandom_range(99) < 20) begin
            case (t_fault'($urandom_range(4)))
                FAULT_CRC:          crc_ok = 1'b0;
                FAULT_DFL_LONG:     dfl = len - 80 + 8 * $urandom_range(1, 4);
                FAULT_DFL_ALIGN:    dfl = dfl | $urandom_range(1, 7);
                FAULT_SYNCD_BEYOND: syncd = dfl + 8 * $urandom_range(1, 8);
                default:            syncd = syncd | $urandom_range(1, 7);
            endcase
        end else if (!force_long && $urandom_range(99) < 6) begin
            wild = 1'b1;
            len = $urandom_range(65535);
            dfl = $urandom_range(65535);
            syncd = $urandom_range(65535);
            crc_ok = 1'($urandom_range(1));
        end
        nbits = wild ? $urandom_range(1, 120) : len;
        if (!force_long && $urandom_range(9) == 0) nbits = $urandom_range(1, nbits);
        send_frame(16'(dfl), 16'(syncd), crc_ok, 16'(len), nbits, fill, 1'b0, ST_DATA);
        if (!force_long && $urandom_range(6) == 0) send_noise($urandom_range(1, 6));
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (hold_want && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_out
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (deframed_q.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected transaction: byte %02h status %0d last %0b",
                             o_data_byte, o_status, o_frame_last);
                fail_count++;
            end else begin
                want = deframed_q.pop_front();
                if (o_data_byte !== want.data_byte || o_status !== want.status ||
                    o_frame_last !== want.frame_last) begin
                    if (fail_count < 10)
                        $display({"mismatch: expected byte %02h status %0d last %0b, ",
                                  "got %02h %0d %0b"},
                                 want.data_byte, want.status, want.frame_last,
                                 o_data_byte, o_status, o_frame_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int row;
        int rand_base;
        int done;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (row = 0; row < PLAN_ROWS; row++) begin
            if (!PLAN[row].start)
                send_noise(PLAN[row].nbits);
            else
                send_frame(PLAN[row].dfl, PLAN[row].syncd, PLAN[row].crc_ok,
                           PLAN[row].len_field, PLAN[row].nbits, PLAN[row].fill,
                           PLAN[row].typed, PLAN[row].st);
        end
        rand_base = bits_taken;
        while (bits_taken - rand_base < RANDOM_BITS) begin
            done = bits_taken - rand_base;
            if (done >= 2 * RANDOM_BITS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (done >= RANDOM_BITS / 3) begin
                tx_idle_pct = 82;
                rx_idle_pct = 27;
            end
            if (done >= 2 * RANDOM_BITS / 3 && !hold_want) begin
                hold_want = 1'b1;
                random_frame(1'b1);
            end else begin
                random_frame(1'b0);
            end
        end
        i_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
design/bbdh_pkg.sv
design/bbdh_front.sv
design/bbdh_queue.sv
design/baseband_frame_deheader.sv
bench/testbench.sv
